/* src/vpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared types, codes and constants of the video port and line timing block.
// ----------------------------------------------------------------------------
package vpt_pkg;

   // Default geometry
   localparam int VRAM_DEPTH_DEF      = 16384;
   localparam int DOTS_PER_LINE_DEF   = 320;
   localparam int LINES_PER_FRAME_DEF = 262;
   localparam int VBLANK_LINE_DEF     = 234;
   localparam int ACTIVE_LINES_DEF    = 192;

   // Fixed widths
   localparam int ADDR_W = 14;
   localparam int CNT_W  = 9;

   // Port opcodes; code 7 is unused
   typedef enum logic [2:0] {
      OP_CTRL_WRITE = 3'd0,
      OP_DATA_WRITE = 3'd1,
      OP_DATA_READ  = 3'd2,
      OP_STATUS     = 3'd3,
      OP_HCOUNT     = 3'd4,
      OP_VCOUNT     = 3'd5,
      OP_TICK       = 3'd6
   } vpt_op_type;

   // Access codes latched by the second control byte
   typedef enum logic [1:0] {
      CODE_VRAM_READ  = 2'd0,
      CODE_VRAM_WRITE = 2'd1,
      CODE_REG_WRITE  = 2'd2,
      CODE_CRAM_WRITE = 2'd3
   } vpt_code_type;

   // Internal register indexes that matter here
   localparam logic [3:0] REG_MODE1     = 4'd0;
   localparam logic [3:0] REG_MODE2     = 4'd1;
   localparam logic [3:0] REG_LINE_LOAD = 4'd10;

   // Status bits
   localparam logic [7:0] ST_INT  = 8'h80;
   localparam logic [7:0] ST_OVR  = 8'h40;
   localparam logic [7:0] ST_COLL = 8'h20;
   localparam logic [7:0] ST_VBL  = 8'h08;
   localparam logic [7:0] ST_FR   = 8'h01;
   localparam logic [7:0] ST_LOW_ONES = 8'h1f;

   // Events raised by one dot tick
   typedef struct packed {
      logic line_end;
      logic frame_wrap;
      logic vblank_start;
      logic line_fire;
   } vpt_tick_evt_type;

endpackage

/* src/vpt_vram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_vram
// Single-port video memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module vpt_vram #(
   parameter int DEPTH  = vpt_pkg::VRAM_DEPTH_DEF,
   parameter int IDX_W  = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] addr,
   input  logic [7:0]       wr_data,
   output logic [7:0]       rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

/* src/vpt_timing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_timing
// Dot and line counters and the line interrupt down-counter.
// ----------------------------------------------------------------------------
module vpt_timing #(
   parameter int DOTS_PER_LINE   = vpt_pkg::DOTS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = vpt_pkg::LINES_PER_FRAME_DEF,
   parameter int VBLANK_LINE     = vpt_pkg::VBLANK_LINE_DEF,
   parameter int ACTIVE_LINES    = vpt_pkg::ACTIVE_LINES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick,
   input  logic                         line_irq_en,
   input  logic [7:0]                   line_reload,
   output logic [vpt_pkg::CNT_W-1:0]    dot_count,
   output logic [vpt_pkg::CNT_W-1:0]    line_count,
   output vpt_pkg::vpt_tick_evt_type    evt
);

   localparam int CW = vpt_pkg::CNT_W;

   logic [CW-1:0] dot_ff, dot_in;
   logic [CW-1:0] line_ff, line_in;
   logic [7:0]    lic_ff, lic_in;
   logic [CW:0]   dot_inc;
   logic [CW:0]   line_inc;
   logic [CW-1:0] line_new;

   always_comb begin
      dot_inc  = {1'b0, dot_ff} + 1'b1;
      line_inc = {1'b0, line_ff} + 1'b1;
      dot_in   = dot_ff;
      line_in  = line_ff;
      lic_in   = lic_ff;
      evt      = '0;
      line_new = line_inc[CW-1:0];
      if (line_inc >= (CW+1)'(LINES_PER_FRAME)) begin
         line_new = '0;
      end
      if (tick) begin
         if (dot_inc < (CW+1)'(DOTS_PER_LINE)) begin
            dot_in = dot_inc[CW-1:0];
         end else begin
            evt.line_end   = 1'b1;
            evt.frame_wrap = (line_inc >= (CW+1)'(LINES_PER_FRAME));
            dot_in  = '0;
            line_in = line_new;
            // reload outside the active lines; inside, count down, and fire and reload at zero
            if (line_new == '0 || line_new > CW'(ACTIVE_LINES)) begin
               lic_in = line_reload;
            end else if (lic_ff == '0) begin
               evt.line_fire = line_irq_en;
               lic_in        = line_reload;
            end else begin
               lic_in = lic_ff - 1'b1;
            end
            evt.vblank_start = (line_new == CW'(VBLANK_LINE));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         line_ff <= '0;
         lic_ff  <= '0;
      end else begin
         dot_ff  <= dot_in;
         line_ff <= line_in;
         lic_ff  <= lic_in;
      end
   end

   assign dot_count  = dot_ff;
   assign line_count = line_ff;

endmodule

/* src/video_port_and_line_timing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_port_and_line_timing
// CPU port interface of a tile video chip: control latch, video memory
// access with read buffer, status and interrupt flags, line timing.
// ----------------------------------------------------------------------------
// Response: registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless a held response stalls; each takes
//   at most one read or write of the single-port video memory, whose read data
//   lands in the read buffer the next cycle, forwarded to a data read right after.
// Reset: synchronous; clears counters, flags, latch and registers. Video
//   memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module video_port_and_line_timing #(
   parameter int VRAM_DEPTH      = vpt_pkg::VRAM_DEPTH_DEF,
   parameter int DOTS_PER_LINE   = vpt_pkg::DOTS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = vpt_pkg::LINES_PER_FRAME_DEF,
   parameter int VBLANK_LINE     = vpt_pkg::VBLANK_LINE_DEF,
   parameter int ACTIVE_LINES    = vpt_pkg::ACTIVE_LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_data_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_cpu_irq,
   output logic        rsp_line_irq_pending,
   output logic        rsp_frame_irq_pending,
   output logic        rsp_cram_write,
   output logic [13:0] rsp_cram_addr,
   output logic [7:0]  rsp_cram_data
);

   localparam int IDX_W = $clog2(VRAM_DEPTH);
   localparam int AW    = vpt_pkg::ADDR_W;
   localparam int CW    = vpt_pkg::CNT_W;

   // Reduce a 14-bit address modulo the memory depth. The quotient stays
   // below 16 only for depths of 1024 or more, where four conditional subtracts do.
   function automatic logic [IDX_W-1:0] vram_index(input logic [AW-1:0] a);
      logic [19:0] r;
      r = {6'd0, a};
      for (int k = 3; k >= 0; k--) begin
         if (r >= (20'(VRAM_DEPTH) << k)) begin
            r = r - (20'(VRAM_DEPTH) << k);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [AW-1:0]         addr_ff, addr_in;
   vpt_pkg::vpt_code_type code_ff, code_in;
   logic                  first_ff, first_in;
   logic [7:0]            rbuf_ff;
   logic                  load_pend_ff;
   logic [7:0]            status_ff, status_in;
   logic                  irq_ff, irq_in;
   logic                  line_pend_ff, line_pend_in;
   logic                  frame_pend_ff, frame_pend_in;
   // only the control register bits this block acts on are kept
   logic                  line_en_ff, line_en_in;
   logic                  frame_en_ff, frame_en_in;
   logic [7:0]            line_load_ff, line_load_in;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  rd_ff, rd_in;
   logic        cw_ff, cw_in;
   logic [13:0] ca_ff, ca_in;
   logic [7:0]  cd_ff, cd_in;

   // ---------------------------------------------------------------------
   // Datapath signals
   // ---------------------------------------------------------------------
   logic                        accept;
   vpt_pkg::vpt_op_type         op;
   logic [AW-1:0]               ctrl_addr;
   logic [AW-1:0]               mem_addr;
   logic                        mem_rd, mem_wr;
   logic [7:0]                  mem_rdata;
   logic [7:0]                  rbuf_fwd;
   logic                        rbuf_load;
   logic                        tick;
   logic [CW-1:0]               dot_count, line_count;
   vpt_pkg::vpt_tick_evt_type   evt;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = vpt_pkg::vpt_op_type'(req_opcode);
   assign tick      = accept && (op == vpt_pkg::OP_TICK);

   // second control byte forms the full address
   assign ctrl_addr = {req_data_in[5:0], addr_ff[7:0]};

   // the previous prefetch lands this cycle: forward it
   assign rbuf_fwd = load_pend_ff ? mem_rdata : rbuf_ff;

   // ---------------------------------------------------------------------
   // Port decode: next state for one accepted request
   // ---------------------------------------------------------------------
   always_comb begin
      addr_in       = addr_ff;
      code_in       = code_ff;
      first_in      = first_ff;
      status_in     = status_ff;
      irq_in        = irq_ff;
      line_pend_in  = line_pend_ff;
      frame_pend_in = frame_pend_ff;
      line_en_in    = line_en_ff;
      frame_en_in   = frame_en_ff;
      line_load_in  = line_load_ff;
      mem_addr      = addr_ff;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      rbuf_load     = 1'b0;
      rd_in         = '0;
      cw_in         = 1'b0;
      ca_in         = '0;
      cd_in         = '0;

      if (accept) begin
         unique case (op)
            vpt_pkg::OP_CTRL_WRITE: begin
               if (first_ff) begin
                  // first byte: low address
                  first_in = 1'b0;
                  addr_in  = {addr_ff[AW-1:8], req_data_in};
               end else begin
                  first_in = 1'b1;
                  code_in  = vpt_pkg::vpt_code_type'(req_data_in[7:6]);
                  addr_in  = ctrl_addr;
                  if (code_in == vpt_pkg::CODE_VRAM_READ) begin
                     // prefetch into the read buffer, advance
                     mem_addr = ctrl_addr;
                     mem_rd   = 1'b1;
                     addr_in  = ctrl_addr + 1'b1;
                  end else if (code_in == vpt_pkg::CODE_REG_WRITE) begin
                     if (req_data_in[3:0] == vpt_pkg::REG_MODE1) begin
                        line_en_in = addr_ff[4];
                     end
                     if (req_data_in[3:0] == vpt_pkg::REG_MODE2) begin
                        frame_en_in = addr_ff[5];
                     end
                     if (req_data_in[3:0] == vpt_pkg::REG_LINE_LOAD) begin
                        line_load_in = addr_ff[7:0];
                     end
                  end
               end
            end
            vpt_pkg::OP_DATA_WRITE: begin
               first_in  = 1'b1;
               rbuf_load = 1'b1;
               if (code_ff == vpt_pkg::CODE_CRAM_WRITE) begin
                  cw_in = 1'b1;
                  ca_in = addr_ff;
                  cd_in = req_data_in;
               end else begin
                  mem_wr = 1'b1;
               end
               addr_in = addr_ff + 1'b1;
            end
            vpt_pkg::OP_DATA_READ: begin
               rd_in    = rbuf_fwd;
               mem_rd   = 1'b1;
               addr_in  = addr_ff + 1'b1;
               first_in = 1'b1;
            end
            vpt_pkg::OP_STATUS: begin
               rd_in     = status_ff | vpt_pkg::ST_LOW_ONES;
               status_in = '0;
               irq_in    = 1'b0;
               first_in  = 1'b1;
            end
            vpt_pkg::OP_HCOUNT: begin
               rd_in = dot_count[7:0];
            end
            vpt_pkg::OP_VCOUNT: begin
               rd_in = line_count[7:0];
            end
            vpt_pkg::OP_TICK: begin
               // drop the line at every line end
               if (evt.line_end) begin
                  irq_in = 1'b0;
               end
               if (evt.frame_wrap) begin
                  frame_pend_in = 1'b0;
                  status_in = (status_ff ^ vpt_pkg::ST_FR) &
                              ~(vpt_pkg::ST_INT | vpt_pkg::ST_VBL |
                                vpt_pkg::ST_OVR | vpt_pkg::ST_COLL);
               end
               if (evt.line_fire) begin
                  line_pend_in = 1'b1;
               end
               // raise vblank status and the interrupt line
               if (evt.vblank_start) begin
                  status_in = status_in | vpt_pkg::ST_VBL | vpt_pkg::ST_INT;
                  irq_in    = 1'b1;
                  if (frame_en_ff) begin
                     frame_pend_in = 1'b1;
                  end
               end
            end
            default: begin
               // unused opcode: no state change
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         code_ff       <= vpt_pkg::CODE_VRAM_READ;
         first_ff      <= 1'b1;
         rbuf_ff       <= '0;
         load_pend_ff  <= 1'b0;
         status_ff     <= '0;
         irq_ff        <= 1'b0;
         line_pend_ff  <= 1'b0;
         frame_pend_ff <= 1'b0;
         line_en_ff    <= 1'b0;
         frame_en_ff   <= 1'b0;
         line_load_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         addr_ff       <= addr_in;
         code_ff       <= code_in;
         first_ff      <= first_in;
         status_ff     <= status_in;
         irq_ff        <= irq_in;
         line_pend_ff  <= line_pend_in;
         frame_pend_ff <= frame_pend_in;
         line_en_ff    <= line_en_in;
         frame_en_ff   <= frame_en_in;
         line_load_ff  <= line_load_in;
         load_pend_ff  <= mem_rd;
         // a data write overrides an older prefetch landing now
         if (rbuf_load) begin
            rbuf_ff <= req_data_in;
         end else if (load_pend_ff) begin
            rbuf_ff <= mem_rdata;
         end
         if (req_ready) begin
            rsp_valid_ff <= req_valid;
         end
      end
   end

   // hold the response payload until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= rd_in;
         cw_ff <= cw_in;
         ca_ff <= ca_in;
         cd_ff <= cd_in;
      end
   end

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   vpt_vram #(
      .DEPTH (VRAM_DEPTH),
      .IDX_W (IDX_W)
   ) u_vram (
      .clock      (clock),
      .wr_en      (mem_wr),
      .rd_en      (mem_rd),
      .addr       (vram_index(mem_addr)),
      .wr_data    (req_data_in),
      .rd_data_ff (mem_rdata)
   );

   vpt_timing #(
      .DOTS_PER_LINE   (DOTS_PER_LINE),
      .LINES_PER_FRAME (LINES_PER_FRAME),
      .VBLANK_LINE     (VBLANK_LINE),
      .ACTIVE_LINES    (ACTIVE_LINES)
   ) u_timing (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .line_irq_en (line_en_ff),
      .line_reload (line_load_ff),
      .dot_count   (dot_count),
      .line_count  (line_count),
      .evt         (evt)
   );

   // ---------------------------------------------------------------------
   // Outputs: interrupt bits reflect the state after the request
   // ---------------------------------------------------------------------
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rd_ff;
   assign rsp_cpu_irq           = irq_ff;
   assign rsp_line_irq_pending  = line_pend_ff;
   assign rsp_frame_irq_pending = frame_pend_ff;
   assign rsp_cram_write        = cw_ff;
   assign rsp_cram_addr         = ca_ff;
   assign rsp_cram_data         = cd_ff;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for video_port_and_line_timing. A short table of
// directed port accesses runs first, then a long random mix of control
// pairs, data writes and reads, status and counter reads, and runs of dot
// ticks. The runs of ticks carry the counters across several line ends,
// where the line interrupt counter reloads and fires. A cycle-free model in
// the bench predicts every response but those of the fixed directed rows,
// and responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;

   // Default geometry, handed down to the block
   localparam int P_VRAM_DEPTH = vpt_pkg::VRAM_DEPTH_DEF;
   localparam int P_DOTS       = vpt_pkg::DOTS_PER_LINE_DEF;
   localparam int P_LINES      = vpt_pkg::LINES_PER_FRAME_DEF;
   localparam int P_VBLANK     = vpt_pkg::VBLANK_LINE_DEF;
   localparam int P_ACTIVE     = vpt_pkg::ACTIVE_LINES_DEF;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int LINE_IRQ_EN_BIT  = 4;
   localparam int FRAME_IRQ_EN_BIT = 5;

   localparam int IDLE_PCT      = 29;
   localparam int N_PORT_ITEMS  = 1950;
   localparam int QUIET_FROM    = 700;
   localparam int QUIET_TO      = 1000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        cpu_irq;
      logic        line_irq_pending;
      logic        frame_irq_pending;
      logic        cram_write;
      logic [13:0] cram_addr;
      logic [7:0]  cram_data;
   } port_result_type;

   // One directed request; fixed rows carry a hand-written response
   typedef struct packed {
      logic [2:0]      op;
      logic [7:0]      data;
      logic            fixed;
      port_result_type want;
   } stim_row_type;

   localparam port_result_type RES_ZERO = '0;
   localparam int NUM_DIRECTED = 26;

   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // out of reset: status shows only the forced low ones
      '{vpt_pkg::OP_STATUS,     8'h00, 1'b1,
        '{8'h1f, 1'b0, 1'b0, 1'b0, 1'b0, 14'h0, 8'h00}},
      '{vpt_pkg::OP_HCOUNT,     8'h00, 1'b1, RES_ZERO},
      '{vpt_pkg::OP_VCOUNT,     8'h00, 1'b1, RES_ZERO},
      '{OP_UNUSED,              8'hff, 1'b1, RES_ZERO},
      // write 0xff, 0x00 at address 0 and 1
      '{vpt_pkg::OP_CTRL_WRITE, 8'h00, 1'b1, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h40, 1'b1, RES_ZERO},
      '{vpt_pkg::OP_DATA_WRITE, 8'hff, 1'b1, RES_ZERO},
      '{vpt_pkg::OP_DATA_WRITE, 8'h00, 1'b1, RES_ZERO},
      // top address, wraps to zero afterwards
      '{vpt_pkg::OP_CTRL_WRITE, 8'hff, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h7f, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_DATA_WRITE, 8'ha5, 1'b0, RES_ZERO},
      // prefetch the top address, then read through the wrap
      '{vpt_pkg::OP_CTRL_WRITE, 8'hff, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h3f, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_DATA_READ,  8'h00, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_DATA_READ,  8'hff, 1'b0, RES_ZERO},
      // line reload register and frame interrupt enable
      '{vpt_pkg::OP_CTRL_WRITE, 8'h03, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h8a, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h20, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h81, 1'b0, RES_ZERO},
      // status read rearms the latch, a counter read does not
      '{vpt_pkg::OP_CTRL_WRITE, 8'h10, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_STATUS,     8'h00, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'h10, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_HCOUNT,     8'h00, 1'b0, RES_ZERO},
      '{vpt_pkg::OP_CTRL_WRITE, 8'hc0, 1'b0, RES_ZERO},
      // colour RAM write reported on the response
      '{vpt_pkg::OP_DATA_WRITE, 8'h3c, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 14'h0010, 8'h3c}},
      '{vpt_pkg::OP_TICK,       8'h00, 1'b0, RES_ZERO}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = 3'd0;
   logic [7:0]  req_data_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_cpu_irq;
   logic        rsp_line_irq_pending;
   logic        rsp_frame_irq_pending;
   logic        rsp_cram_write;
   logic [13:0] rsp_cram_addr;
   logic [7:0]  rsp_cram_data;

   // Model state of the port interface
   logic [7:0]            vram_image [P_VRAM_DEPTH];
   bit                    vram_written [P_VRAM_DEPTH];
   logic [13:0]           recent_vram_addrs [$];
   logic [7:0]            reg_file [16];
   logic [13:0]           cur_addr;
   vpt_pkg::vpt_code_type cur_code;
   bit                    first_byte_due;
   logic [7:0]            prefetch_buf;
   logic [7:0]            status_bits;
   logic [8:0]            dot_pos;
   logic [8:0]            line_pos;
   logic [7:0]            line_countdown;
   bit                    irq_line;
   bit                    line_flag;
   bit                    frame_flag;

   port_result_type port_results_due [$];
   port_result_type oldest_due;
   int              mismatch_count = 0;
   int              port_items = 0;
   bit              quiet = 1'b0;

   video_port_and_line_timing #(
      .VRAM_DEPTH      (P_VRAM_DEPTH),
      .DOTS_PER_LINE   (P_DOTS),
      .LINES_PER_FRAME (P_LINES),
      .VBLANK_LINE     (P_VBLANK),
      .ACTIVE_LINES    (P_ACTIVE)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_data_in           (req_data_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_cpu_irq           (rsp_cpu_irq),
      .rsp_line_irq_pending  (rsp_line_irq_pending),
      .rsp_frame_irq_pending (rsp_frame_irq_pending),
      .rsp_cram_write        (rsp_cram_write),
      .rsp_cram_addr         (rsp_cram_addr),
      .rsp_cram_data         (rsp_cram_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one request to the model and return the response it causes.
   function automatic port_result_type predict_port_access(input logic [2:0] op,
                                                           input logic [7:0] d);
      port_result_type r;
      r = '0;
      case (op)
         vpt_pkg::OP_CTRL_WRITE: begin
            if (first_byte_due) begin
               first_byte_due = 1'b0;
               cur_addr[7:0] = d;
            end else begin
               cur_code = vpt_pkg::vpt_code_type'(d[7:6]);
               cur_addr[13:8] = d[5:0];
               first_byte_due = 1'b1;
               if (cur_code == vpt_pkg::CODE_VRAM_READ) begin
                  prefetch_buf = vram_image[cur_addr % P_VRAM_DEPTH];
                  cur_addr = cur_addr + 14'd1;
               end else if (cur_code == vpt_pkg::CODE_REG_WRITE) begin
                  reg_file[d[3:0]] = cur_addr[7:0];
               end
            end
         end
         vpt_pkg::OP_DATA_WRITE: begin
            first_byte_due = 1'b1;
            prefetch_buf = d;
            if (cur_code == vpt_pkg::CODE_CRAM_WRITE) begin
               r.cram_write = 1'b1;
               r.cram_addr  = cur_addr;
               r.cram_data  = d;
            end else begin
               vram_image[cur_addr % P_VRAM_DEPTH] = d;
               vram_written[cur_addr % P_VRAM_DEPTH] = 1'b1;
               recent_vram_addrs.push_back(cur_addr);
               if (recent_vram_addrs.size() > 32)
                  void'(recent_vram_addrs.pop_front());
            end
            cur_addr = cur_addr + 14'd1;
         end
         vpt_pkg::OP_DATA_READ: begin
            r.read_data = prefetch_buf;
            prefetch_buf = vram_image[cur_addr % P_VRAM_DEPTH];
            cur_addr = cur_addr + 14'd1;
            first_byte_due = 1'b1;
         end
         vpt_pkg::OP_STATUS: begin
            r.read_data = status_bits | vpt_pkg::ST_LOW_ONES;
            status_bits = '0;
            irq_line = 1'b0;
            first_byte_due = 1'b1;
         end
         vpt_pkg::OP_HCOUNT: r.read_data = dot_pos[7:0];
         vpt_pkg::OP_VCOUNT: r.read_data = line_pos[7:0];
         vpt_pkg::OP_TICK: begin
            dot_pos = dot_pos + 9'd1;
            if (dot_pos >= P_DOTS) begin
               irq_line = 1'b0;
               dot_pos = '0;
               line_pos = line_pos + 9'd1;
               if (line_pos >= P_LINES) begin
                  line_pos = '0;
                  frame_flag = 1'b0;
                  status_bits = status_bits ^ vpt_pkg::ST_FR;
                  status_bits = status_bits & ~(vpt_pkg::ST_INT | vpt_pkg::ST_VBL |
                                                vpt_pkg::ST_OVR | vpt_pkg::ST_COLL);
               end
               if (line_pos == 0 || line_pos > P_ACTIVE) begin
                  line_countdown = reg_file[vpt_pkg::REG_LINE_LOAD];
               end else if (line_countdown == 0) begin
                  if (reg_file[vpt_pkg::REG_MODE1][LINE_IRQ_EN_BIT])
                     line_flag = 1'b1;
                  line_countdown = reg_file[vpt_pkg::REG_LINE_LOAD];
               end else begin
                  line_countdown = line_countdown - 8'd1;
               end
               if (line_pos == P_VBLANK) begin
                  status_bits = status_bits | vpt_pkg::ST_VBL | vpt_pkg::ST_INT;
                  irq_line = 1'b1;
                  if (reg_file[vpt_pkg::REG_MODE2][FRAME_IRQ_EN_BIT])
                     frame_flag = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.cpu_irq           = irq_line;
      r.line_irq_pending  = line_flag;
      r.frame_irq_pending = frame_flag;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // Present one request, hold it until accepted, then queue its response.
   // A random gap of idle cycles may go first; drop valid only for a gap.
   task automatic send_request(input logic [2:0] op, input logic [7:0] d,
                               input logic fixed = 1'b0,
                               input port_result_type want = '0);
      port_result_type r;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!quiet && $urandom_range(99) < IDLE_PCT);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_data_in <= d;
      do @(posedge clock); while (!req_ready);
      r = predict_port_access(op, d);
      port_results_due.push_back(fixed ? want : r);
      port_items++;
      quiet = (port_items >= QUIET_FROM && port_items < QUIET_TO);
   endtask

   // Send a control byte; turn a prefetch of unwritten memory into a
   // plain address set so that no undefined entry is ever read.
   task automatic safe_ctrl_write(input logic [7:0] d);
      logic [7:0] b;
      b = d;
      if (!first_byte_due && b[7:6] == vpt_pkg::CODE_VRAM_READ &&
          !vram_written[{b[5:0], cur_addr[7:0]} % P_VRAM_DEPTH])
         b[7:6] = vpt_pkg::CODE_VRAM_WRITE;
      send_request(vpt_pkg::OP_CTRL_WRITE, b);
   endtask

   task automatic aim_address(input vpt_pkg::vpt_code_type code,
                              input logic [13:0] addr);
      safe_ctrl_write(addr[7:0]);
      safe_ctrl_write({code, addr[13:8]});
   endtask

   // Read when the next entry holds data, else write it first
   task automatic read_or_write_data();
      if (vram_written[cur_addr % P_VRAM_DEPTH])
         send_request(vpt_pkg::OP_DATA_READ, 8'($urandom));
      else
         send_request(vpt_pkg::OP_DATA_WRITE, 8'($urandom));
   endtask

   // Response side: check every accepted response against the oldest
   // prediction, then stall at random outside the quiet stretch.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (port_results_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_due = port_results_due.pop_front();
            check_field("read_data", rsp_read_data, oldest_due.read_data);
            check_field("cpu_irq", rsp_cpu_irq, oldest_due.cpu_irq);
            check_field("line_irq_pending", rsp_line_irq_pending,
                        oldest_due.line_irq_pending);
            check_field("frame_irq_pending", rsp_frame_irq_pending,
                        oldest_due.frame_irq_pending);
            check_field("cram_write", rsp_cram_write, oldest_due.cram_write);
            check_field("cram_addr", rsp_cram_addr, oldest_due.cram_addr);
            check_field("cram_data", rsp_cram_data, oldest_due.cram_data);
         end
      end
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      int          pick;
      int          sel;
      int          run_len;
      logic [3:0]  reg_idx;
      logic [7:0]  reg_val;

      // Model state after reset
      foreach (vram_written[i]) vram_written[i] = 1'b0;
      foreach (reg_file[i]) reg_file[i] = '0;
      cur_addr       = '0;
      cur_code       = vpt_pkg::CODE_VRAM_READ;
      first_byte_due = 1'b1;
      prefetch_buf   = '0;
      status_bits    = '0;
      dot_pos        = '0;
      line_pos       = '0;
      line_countdown = '0;
      irq_line       = 1'b0;
      line_flag      = 1'b0;
      frame_flag     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int k = 0; k < NUM_DIRECTED; k++)
         send_request(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].data,
                      DIRECTED_ROWS[k].fixed, DIRECTED_ROWS[k].want);

      // Random mix; runs of ticks carry the timing across line ends
      while (port_items < N_PORT_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            run_len = ($urandom_range(99) < 5) ? $urandom_range(200, 400)
                                               : $urandom_range(1, 20);
            repeat (run_len) begin
               if (port_items < N_PORT_ITEMS) begin
                  if ($urandom_range(99) < 3)
                     send_request($urandom_range(1) ? vpt_pkg::OP_STATUS
                                                    : vpt_pkg::OP_VCOUNT,
                                  8'($urandom));
                  else
                     send_request(vpt_pkg::OP_TICK, 8'($urandom));
               end
            end
         end else if (pick < 45) begin
            sel = $urandom_range(99);
            if (sel < 30 && recent_vram_addrs.size() != 0) begin
               aim_address(vpt_pkg::CODE_VRAM_READ,
                           recent_vram_addrs[$urandom_range(recent_vram_addrs.size() - 1)]);
            end else if (sel < 50) begin
               // favor the registers that steer the interrupts
               case ($urandom_range(3))
                  0: reg_idx = vpt_pkg::REG_MODE1;
                  1: reg_idx = vpt_pkg::REG_MODE2;
                  2: reg_idx = vpt_pkg::REG_LINE_LOAD;
                  default: reg_idx = 4'($urandom);
               endcase
               if (reg_idx == vpt_pkg::REG_LINE_LOAD && $urandom_range(3) != 0)
                  reg_val = 8'($urandom_range(6));
               else
                  reg_val = 8'($urandom);
               aim_address(vpt_pkg::CODE_REG_WRITE, {2'($urandom), reg_idx, reg_val});
            end else begin
               aim_address(vpt_pkg::vpt_code_type'($urandom_range(3)), 14'($urandom));
            end
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 8))
               send_request(vpt_pkg::OP_DATA_WRITE, 8'($urandom));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) read_or_write_data();
         end else if (pick < 91) begin
            send_request(vpt_pkg::OP_STATUS, 8'($urandom));
         end else if (pick < 96) begin
            send_request(pick[0] ? vpt_pkg::OP_HCOUNT : vpt_pkg::OP_VCOUNT,
                         8'($urandom));
         end else if (pick < 98) begin
            // lone control byte; knocks the byte pairing out of step
            safe_ctrl_write(8'($urandom));
         end else begin
            send_request(OP_UNUSED, 8'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then allow time for strays
      while (port_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #(20_000_000);
      $display("FAIL");
      $finish;
   end

endmodule
